// ===== hdl/erp_pkg.sv =====
// ----------------------------------------------------------------------------
// erp_pkg
// Shared types and constants of the elevation record parser.
// ----------------------------------------------------------------------------
package erp_pkg;

    localparam int POSTS_W = 12;
    localparam int POS_W   = 14;
    localparam int SUM_W   = 32;
    localparam int WORD_W  = 16;

    localparam logic [POSTS_W-1:0] POINTS_RESET  = 12'd1201;
    localparam logic [7:0]         SENTINEL_BYTE = 8'hAA;
    localparam logic [WORD_W-1:0]  NULL_WORD     = 16'hFFFF;

    // header byte positions (low byte of each word; the sentinel is byte 0)
    localparam logic [POS_W-1:0] POS_SENTINEL   = 14'd0;
    localparam logic [POS_W-1:0] POS_BLOCK_LO   = 14'd3;
    localparam logic [POS_W-1:0] POS_LON_LO     = 14'd5;
    localparam logic [POS_W-1:0] POS_LAT_LO     = 14'd7;
    localparam logic [POS_W-1:0] POS_FIRST_POST = 14'd9;
    localparam logic [POS_W-1:0] HEADER_BYTES   = 14'd8;
    localparam logic [POS_W-1:0] SUM_LAST_OFS   = 14'd3;

    localparam logic KIND_POST    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] record_byte;
        logic       frame_start;
    } erp_beat_t;

    typedef struct packed {
        logic                     result_kind;
        logic [POSTS_W-1:0]       post_index;
        logic signed [WORD_W-1:0] elevation;
        logic                     null_post;
        logic [WORD_W-1:0]        block_count;
        logic [WORD_W-1:0]        lon_index;
        logic [WORD_W-1:0]        lat_index;
        logic                     sentinel_ok;
        logic                     checksum_ok;
    } erp_result_t;

endpackage

// ===== hdl/erp_in_stage.sv =====
// ----------------------------------------------------------------------------
// erp_in_stage
// Input register: holds one byte beat until the parser core takes it.
// ----------------------------------------------------------------------------
module erp_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  erp_pkg::erp_beat_t s_beat,
    output logic               beat_valid,
    output erp_pkg::erp_beat_t beat,
    input  logic               beat_take
);

    logic               valid_reg;
    logic               valid_next;
    erp_pkg::erp_beat_t beat_reg;
    logic               load;

    assign s_ready    = !valid_reg || beat_take;
    assign load       = s_valid && s_ready;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (beat_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= s_beat;
        end
    end

endmodule

// ===== hdl/erp_core.sv =====
// ----------------------------------------------------------------------------
// erp_core
// Record state, byte sum and post decode; one byte per cycle while beat_take is high.
// ----------------------------------------------------------------------------
module erp_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_write,
    input  logic [erp_pkg::POSTS_W-1:0]          cfg_points,
    input  logic                                 beat_valid,
    input  erp_pkg::erp_beat_t                   beat,
    input  logic                                 beat_take,
    output logic                                 emit,
    output erp_pkg::erp_result_t                 result
);

    logic [erp_pkg::POSTS_W-1:0] points_reg;

    logic [erp_pkg::POS_W-1:0]   pos_reg, pos_next, pos_eff;
    logic [7:0]                  hold_reg, hold_next, hold_eff;
    logic [erp_pkg::SUM_W-1:0]   sum_reg, sum_next, sum_eff;
    logic [erp_pkg::SUM_W-1:0]   shift_reg, shift_next, shift_eff;
    logic [erp_pkg::WORD_W-1:0]  block_reg, block_next, block_eff;
    logic [erp_pkg::WORD_W-1:0]  lon_reg, lon_next, lon_eff;
    logic [erp_pkg::WORD_W-1:0]  lat_reg, lat_next, lat_eff;
    logic                        sent_reg, sent_next, sent_eff;
    logic [erp_pkg::POSTS_W-1:0] pcnt_reg, pcnt_next, pcnt_eff;

    logic [erp_pkg::POS_W-1:0]   data_end;
    logic                        in_data;
    logic                        is_post;
    logic                        is_summary;
    logic [erp_pkg::WORD_W-1:0]  word;
    logic [erp_pkg::WORD_W-1:0]  mag;
    logic [erp_pkg::SUM_W-1:0]   stored_sum;

    // frame start drops the record in progress before this byte
    assign pos_eff   = beat.frame_start ? '0 : pos_reg;
    assign hold_eff  = beat.frame_start ? '0 : hold_reg;
    assign sum_eff   = beat.frame_start ? '0 : sum_reg;
    assign shift_eff = beat.frame_start ? '0 : shift_reg;
    assign block_eff = beat.frame_start ? '0 : block_reg;
    assign lon_eff   = beat.frame_start ? '0 : lon_reg;
    assign lat_eff   = beat.frame_start ? '0 : lat_reg;
    assign sent_eff  = beat.frame_start ? 1'b0 : sent_reg;
    assign pcnt_eff  = beat.frame_start ? '0 : pcnt_reg;

    assign data_end   = erp_pkg::HEADER_BYTES + {1'b0, points_reg, 1'b0};
    assign in_data    = pos_eff < data_end;
    assign word       = {hold_eff, beat.record_byte};
    assign is_post    = in_data && pos_eff[0] && (pos_eff >= erp_pkg::POS_FIRST_POST);
    assign is_summary = !in_data && ((pos_eff - data_end) >= erp_pkg::SUM_LAST_OFS);
    assign emit       = beat_valid && (is_post || is_summary);
    assign stored_sum = {shift_eff[erp_pkg::SUM_W-9:0], beat.record_byte};
    assign mag        = {1'b0, word[erp_pkg::WORD_W-2:0]};

    always_comb begin
        result = '0;
        if (is_post) begin
            result.result_kind = erp_pkg::KIND_POST;
            result.post_index  = pcnt_eff;
            result.elevation   = word[erp_pkg::WORD_W-1] ? ('0 - mag) : mag;
            result.null_post   = (word == erp_pkg::NULL_WORD);
        end else begin
            result.result_kind = erp_pkg::KIND_SUMMARY;
            result.block_count = block_eff;
            result.lon_index   = lon_eff;
            result.lat_index   = lat_eff;
            result.sentinel_ok = sent_eff;
            result.checksum_ok = (stored_sum == sum_eff);
        end
    end

    always_comb begin
        pos_next   = pos_eff + 14'd1;
        hold_next  = hold_eff;
        sum_next   = sum_eff;
        shift_next = shift_eff;
        block_next = block_eff;
        lon_next   = lon_eff;
        lat_next   = lat_eff;
        sent_next  = sent_eff;
        pcnt_next  = pcnt_eff;
        if (in_data) begin
            sum_next = sum_eff + {24'd0, beat.record_byte};
            if (pos_eff == erp_pkg::POS_SENTINEL) begin
                sent_next = (beat.record_byte == erp_pkg::SENTINEL_BYTE);
            end else if (!pos_eff[0]) begin
                hold_next = beat.record_byte;
            end else if (pos_eff == erp_pkg::POS_BLOCK_LO) begin
                block_next = word;
            end else if (pos_eff == erp_pkg::POS_LON_LO) begin
                lon_next = word;
            end else if (pos_eff == erp_pkg::POS_LAT_LO) begin
                lat_next = word;
            end else if (is_post) begin
                pcnt_next = pcnt_eff + 12'd1;
            end
        end else begin
            shift_next = stored_sum;
            if (is_summary) begin
                // record done: start over at byte 0
                pos_next   = '0;
                hold_next  = '0;
                sum_next   = '0;
                shift_next = '0;
                block_next = '0;
                lon_next   = '0;
                lat_next   = '0;
                sent_next  = 1'b0;
                pcnt_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_reg <= erp_pkg::POINTS_RESET;
            pos_reg    <= '0;
            hold_reg   <= '0;
            sum_reg    <= '0;
            shift_reg  <= '0;
            block_reg  <= '0;
            lon_reg    <= '0;
            lat_reg    <= '0;
            sent_reg   <= 1'b0;
            pcnt_reg   <= '0;
        end else begin
            if (cfg_write) begin
                points_reg <= cfg_points;
            end
            if (beat_take) begin
                pos_reg   <= pos_next;
                hold_reg  <= hold_next;
                sum_reg   <= sum_next;
                shift_reg <= shift_next;
                block_reg <= block_next;
                lon_reg   <= lon_next;
                lat_reg   <= lat_next;
                sent_reg  <= sent_next;
                pcnt_reg  <= pcnt_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_summary_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_take && emit && (result.result_kind == erp_pkg::KIND_SUMMARY)
        |=> (pos_reg == '0) && (sum_reg == '0) && (pcnt_reg == '0))
        else $error("record state not cleared after summary");

    a_post_range: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && (result.result_kind == erp_pkg::KIND_POST)
        |-> (result.elevation != 16'sh8000))
        else $error("decoded post out of range");

    a_null_value: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && (result.result_kind == erp_pkg::KIND_POST) && result.null_post
        |-> (result.elevation == -16'sd32767))
        else $error("null post decoded wrongly");

    a_post_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_take && emit && (result.result_kind == erp_pkg::KIND_POST)
        |=> (pcnt_reg == $past(result.post_index) + 12'd1))
        else $error("post counter did not advance");
`endif

endmodule

// ===== hdl/erp_out_stage.sv =====
// ----------------------------------------------------------------------------
// erp_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module erp_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  erp_pkg::erp_result_t result,
    output logic                 can_take,
    output logic                 m_valid,
    input  logic                 m_ready,
    output erp_pkg::erp_result_t m_result
);

    logic                 valid_reg;
    logic                 valid_next;
    erp_pkg::erp_result_t result_reg;

    assign can_take = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

// ===== hdl/elevation_record_parser.sv =====
// ----------------------------------------------------------------------------
// elevation_record_parser
// Parses big-endian terrain elevation records one byte per beat.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_        in   s_valid / s_ready    s_record_byte, s_frame_start
//  m_        out  m_valid / m_ready    post or end-of-record summary fields
//  cfg_      in   cfg_valid/cfg_ready  cfg_points_per_record
//
//  One byte beat per cycle while the result register is not stalled; a
//  byte's result goes through the input register, then the result register.
//  The input register keeps taking beats while a result waits, until the
//  result register is stalled and the held byte would produce a result.
//  Reset is synchronous, active low; posts per record return to 1201.
// ----------------------------------------------------------------------------
module elevation_record_parser (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_record_byte,
    input  logic                                 s_frame_start,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_result_kind,
    output logic [erp_pkg::POSTS_W-1:0]          m_post_index,
    output logic signed [erp_pkg::WORD_W-1:0]    m_elevation,
    output logic                                 m_null_post,
    output logic [erp_pkg::WORD_W-1:0]           m_block_count,
    output logic [erp_pkg::WORD_W-1:0]           m_lon_index,
    output logic [erp_pkg::WORD_W-1:0]           m_lat_index,
    output logic                                 m_sentinel_ok,
    output logic                                 m_checksum_ok,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [erp_pkg::POSTS_W-1:0]          cfg_points_per_record
);

    erp_pkg::erp_beat_t   s_beat;
    erp_pkg::erp_beat_t   beat;
    erp_pkg::erp_result_t result;
    erp_pkg::erp_result_t m_result;
    logic                 beat_valid;
    logic                 beat_take;
    logic                 emit;
    logic                 out_can_take;

    assign cfg_ready          = 1'b1;
    assign s_beat.record_byte = s_record_byte;
    assign s_beat.frame_start = s_frame_start;

    // advance the held byte unless its result has nowhere to go
    assign beat_take = beat_valid && (!emit || out_can_take);

    erp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take)
    );

    erp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_points (cfg_points_per_record),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take),
        .emit       (emit),
        .result     (result)
    );

    erp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (beat_take && emit),
        .result   (result),
        .can_take (out_can_take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_result_kind = m_result.result_kind;
    assign m_post_index  = m_result.post_index;
    assign m_elevation   = m_result.elevation;
    assign m_null_post   = m_result.null_post;
    assign m_block_count = m_result.block_count;
    assign m_lon_index   = m_result.lon_index;
    assign m_lat_index   = m_result.lat_index;
    assign m_sentinel_ok = m_result.sentinel_ok;
    assign m_checksum_ok = m_result.checksum_ok;

endmodule

// ===== verif/elevation_record_parser_checker.sv =====
// ----------------------------------------------------------------------------
// elevation_record_parser_checker
// Watches the byte, result and post-count channels of the record parser,
// keeps its own copy of the parse state, and compares every result beat
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module elevation_record_parser_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [7:0]                        s_record_byte,
    input  logic                              s_frame_start,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_result_kind,
    input  logic [erp_pkg::POSTS_W-1:0]       m_post_index,
    input  logic signed [erp_pkg::WORD_W-1:0] m_elevation,
    input  logic                              m_null_post,
    input  logic [erp_pkg::WORD_W-1:0]        m_block_count,
    input  logic [erp_pkg::WORD_W-1:0]        m_lon_index,
    input  logic [erp_pkg::WORD_W-1:0]        m_lat_index,
    input  logic                              m_sentinel_ok,
    input  logic                              m_checksum_ok,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [erp_pkg::POSTS_W-1:0]       cfg_points_per_record,
    output int                                mismatch_count,
    output int                                awaited_count,
    output int                                posts_checked,
    output int                                summaries_checked
);

    logic [erp_pkg::POSTS_W-1:0] posts_cfg;
    logic [erp_pkg::POS_W-1:0]   byte_pos;
    logic [7:0]                  hi_byte;
    logic [erp_pkg::SUM_W-1:0]   byte_sum;
    logic [erp_pkg::SUM_W-1:0]   stored_sum;
    logic [erp_pkg::WORD_W-1:0]  block_word;
    logic [erp_pkg::WORD_W-1:0]  lon_word;
    logic [erp_pkg::WORD_W-1:0]  lat_word;
    logic                        sentinel_seen;
    logic [erp_pkg::POSTS_W-1:0] post_num;
    int                          results_seen;

    erp_pkg::erp_result_t parsed_q[$];

    task automatic clear_record();
        byte_pos      = '0;
        hi_byte       = '0;
        byte_sum      = '0;
        stored_sum    = '0;
        block_word    = '0;
        lon_word      = '0;
        lat_word      = '0;
        sentinel_seen = 1'b0;
        post_num      = '0;
    endtask

    // Advance the parse by one byte and queue whatever result it produces.
    task automatic parse_byte(input logic [7:0] b, input logic fs);
        int                         data_end;
        int                         pos;
        logic [erp_pkg::WORD_W-1:0] w;
        logic [14:0]                mag;
        erp_pkg::erp_result_t       r;
        if (fs) begin
            clear_record();
        end
        data_end = int'(erp_pkg::HEADER_BYTES) + 2 * int'(posts_cfg);
        pos      = int'(byte_pos);
        r        = '0;
        if (pos < data_end) begin
            byte_sum = byte_sum + {24'd0, b};
            if (pos == int'(erp_pkg::POS_SENTINEL)) begin
                sentinel_seen = (b == erp_pkg::SENTINEL_BYTE);
            end else if (pos % 2 == 0) begin
                hi_byte = b;
            end else begin
                w = {hi_byte, b};
                if (pos == int'(erp_pkg::POS_BLOCK_LO)) begin
                    block_word = w;
                end else if (pos == int'(erp_pkg::POS_LON_LO)) begin
                    lon_word = w;
                end else if (pos == int'(erp_pkg::POS_LAT_LO)) begin
                    lat_word = w;
                end else if (pos >= int'(erp_pkg::POS_FIRST_POST)) begin
                    // sign-magnitude to two's complement; negative zero gives 0
                    mag           = w[14:0];
                    r.result_kind = erp_pkg::KIND_POST;
                    r.post_index  = post_num;
                    r.elevation   = w[15] ? (16'h0000 - {1'b0, mag}) : {1'b0, mag};
                    r.null_post   = (w == erp_pkg::NULL_WORD);
                    post_num      = post_num + 1'b1;
                    parsed_q.push_back(r);
                end
            end
            byte_pos = byte_pos + 1'b1;
        end else begin
            stored_sum = {stored_sum[erp_pkg::SUM_W-9:0], b};
            if (pos - data_end >= int'(erp_pkg::SUM_LAST_OFS)) begin
                r.result_kind = erp_pkg::KIND_SUMMARY;
                r.block_count = block_word;
                r.lon_index   = lon_word;
                r.lat_index   = lat_word;
                r.sentinel_ok = sentinel_seen;
                r.checksum_ok = (stored_sum == byte_sum);
                parsed_q.push_back(r);
                clear_record();
            end else begin
                byte_pos = byte_pos + 1'b1;
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("result %0d: %s expected %0h, got %0h",
                         results_seen, name, want, got);
            end
        end
    endtask

    task automatic check_result();
        erp_pkg::erp_result_t want;
        if (parsed_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("result %0d arrived with nothing expected: kind %0d index %0d",
                         results_seen, m_result_kind, m_post_index);
            end
        end else begin
            want = parsed_q.pop_front();
            compare_field("result_kind", want.result_kind, m_result_kind);
            compare_field("post_index", want.post_index, m_post_index);
            compare_field("elevation", want.elevation, m_elevation);
            compare_field("null_post", want.null_post, m_null_post);
            compare_field("block_count", want.block_count, m_block_count);
            compare_field("lon_index", want.lon_index, m_lon_index);
            compare_field("lat_index", want.lat_index, m_lat_index);
            compare_field("sentinel_ok", want.sentinel_ok, m_sentinel_ok);
            compare_field("checksum_ok", want.checksum_ok, m_checksum_ok);
            if (want.result_kind == erp_pkg::KIND_POST) begin
                posts_checked++;
            end else begin
                summaries_checked++;
            end
        end
        results_seen++;
    endtask

    // Check the outgoing beat before taking a new byte: a result never
    // leaves in the same cycle as the byte that causes it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            posts_cfg         = erp_pkg::POINTS_RESET;
            clear_record();
            parsed_q.delete();
            mismatch_count    = 0;
            posts_checked     = 0;
            summaries_checked = 0;
            results_seen      = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result();
            end
            if (cfg_valid && cfg_ready) begin
                posts_cfg = cfg_points_per_record;
            end
            if (s_valid && s_ready) begin
                parse_byte(s_record_byte, s_frame_start);
            end
        end
        awaited_count = parsed_q.size();
    end

endmodule

// ===== verif/elevation_record_parser_tb.sv =====
// ----------------------------------------------------------------------------
// elevation_record_parser_tb
// Drives byte streams of terrain elevation records into the parser: a short
// directed set of header and post extremes, then random well-formed records
// mixed with corrupted, truncated and noise streams, over several post counts
// and idle/stall mixes. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module elevation_record_parser_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BYTES  = 1500;
    localparam int PHASES        = 8;

    logic                              aclk                  = 1'b0;
    logic                              aresetn               = 1'b0;
    logic                              s_valid               = 1'b0;
    logic [7:0]                        s_record_byte         = 8'd0;
    logic                              s_frame_start         = 1'b0;
    logic                              m_ready               = 1'b0;
    logic                              cfg_valid             = 1'b0;
    logic [erp_pkg::POSTS_W-1:0]       cfg_points_per_record = '0;

    logic                              s_ready;
    logic                              m_valid;
    logic                              m_result_kind;
    logic [erp_pkg::POSTS_W-1:0]       m_post_index;
    logic signed [erp_pkg::WORD_W-1:0] m_elevation;
    logic                              m_null_post;
    logic [erp_pkg::WORD_W-1:0]        m_block_count;
    logic [erp_pkg::WORD_W-1:0]        m_lon_index;
    logic [erp_pkg::WORD_W-1:0]        m_lat_index;
    logic                              m_sentinel_ok;
    logic                              m_checksum_ok;
    logic                              cfg_ready;

    int mismatch_count;
    int awaited_count;
    int posts_checked;
    int summaries_checked;

    int                          send_idle_pct  = 0;
    int                          stall_pct      = 0;
    int                          bytes_sent     = 0;
    int                          cycle_count    = 0;
    int                          settings_used  = 0;
    logic [erp_pkg::POSTS_W-1:0] posts_now      = erp_pkg::POINTS_RESET;
    logic                        need_start     = 1'b0;

    elevation_record_parser uut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_record_byte         (s_record_byte),
        .s_frame_start         (s_frame_start),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_result_kind         (m_result_kind),
        .m_post_index          (m_post_index),
        .m_elevation           (m_elevation),
        .m_null_post           (m_null_post),
        .m_block_count         (m_block_count),
        .m_lon_index           (m_lon_index),
        .m_lat_index           (m_lat_index),
        .m_sentinel_ok         (m_sentinel_ok),
        .m_checksum_ok         (m_checksum_ok),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_points_per_record (cfg_points_per_record)
    );

    elevation_record_parser_checker parse_check (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_record_byte         (s_record_byte),
        .s_frame_start         (s_frame_start),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_result_kind         (m_result_kind),
        .m_post_index          (m_post_index),
        .m_elevation           (m_elevation),
        .m_null_post           (m_null_post),
        .m_block_count         (m_block_count),
        .m_lon_index           (m_lon_index),
        .m_lat_index           (m_lat_index),
        .m_sentinel_ok         (m_sentinel_ok),
        .m_checksum_ok         (m_checksum_ok),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_points_per_record (cfg_points_per_record),
        .mismatch_count        (mismatch_count),
        .awaited_count         (awaited_count),
        .posts_checked         (posts_checked),
        .summaries_checked     (summaries_checked)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("no progress after %0d cycles, %0d results still awaited",
                     cycle_count, awaited_count);
            $display("FAIL elevation_record_parser");
            $finish;
        end
    end

    // Hold one byte beat on the channel until it is taken.
    task automatic push_byte(input logic [7:0] value, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_record_byte <= value;
        s_frame_start <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Send the low count bytes of seq, most significant first.
    task automatic send_bytes(input logic [127:0] seq, input int count, input logic first);
        for (int i = 0; i < count; i++) begin
            push_byte(seq[8*(count-i)-1 -: 8], (i == 0) ? first : 1'b0);
        end
    endtask

    // Drop valid and wait until every predicted result has left the block.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_posts(input logic [erp_pkg::POSTS_W-1:0] count);
        cfg_valid             <= 1'b1;
        cfg_points_per_record <= count;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        posts_now  = count;
        need_start = 1'b1;
        settings_used++;
    endtask

    function automatic logic [7:0] header_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [erp_pkg::WORD_W-1:0] post_word();
        case ($urandom_range(9))
            0:       return erp_pkg::NULL_WORD;
            1:       return 16'h8000;
            2:       return 16'h7FFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // One record at the current post count; cut_at > 0 stops it early.
    task automatic send_record(input bit good_sentinel, input bit good_sum, input int cut_at);
        logic [7:0]                 rec[$];
        logic [erp_pkg::SUM_W-1:0]  sum;
        logic [erp_pkg::WORD_W-1:0] word;
        logic                       first;
        int                         last;
        rec.push_back(good_sentinel ? erp_pkg::SENTINEL_BYTE : header_byte());
        repeat (7) rec.push_back(header_byte());
        repeat (posts_now) begin
            word = post_word();
            rec.push_back(word[15:8]);
            rec.push_back(word[7:0]);
        end
        sum = '0;
        foreach (rec[i]) sum = sum + {24'd0, rec[i]};
        if (!good_sum) begin
            sum = $urandom_range(1) ? (sum ^ (32'h1 << $urandom_range(31))) : $urandom;
        end
        for (int k = 3; k >= 0; k--) rec.push_back(sum[8*k +: 8]);
        last  = (cut_at > 0) ? cut_at : rec.size();
        first = need_start || ($urandom_range(3) == 0);
        for (int i = 0; i < last; i++) begin
            push_byte(rec[i], (i == 0) ? first : 1'b0);
        end
        need_start = (cut_at > 0);
    endtask

    initial begin
        int phase_end;
        int pick;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero posts: header and checksum only, all-ones and sign-bit header words
        write_posts(12'd0);
        send_bytes(128'hAA00_FFFF_0001_8000_0000_0329, 12, 1'b1);
        settle();

        // back-to-back without frame_start, bad sentinel, null and negative-zero posts
        write_posts(12'd3);
        send_bytes(128'h00FF_0000_FFFF_1234_FFFF_8000_7FFF, 14, 1'b0);
        settle();
        // shrink the post area under a record in progress: next byte closes it
        write_posts(12'd0);
        push_byte(8'h5A, 1'b0);
        settle();

        // largest post count, then restart mid-record
        write_posts(12'd4095);
        push_byte(erp_pkg::SENTINEL_BYTE, 1'b0);
        push_byte(8'h11, 1'b0);
        push_byte(erp_pkg::SENTINEL_BYTE, 1'b1);
        push_byte(8'h22, 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 74; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 74; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            write_posts((phase == 0) ? 12'd1 : erp_pkg::POSTS_W'($urandom_range(0, 6)));
            phase_end = bytes_sent + RANDOM_BYTES / PHASES;
            while (bytes_sent < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 65) begin
                    send_record(1'b1, 1'b1, 0);
                end else if (pick < 75) begin
                    send_record(1'b1, 1'b0, 0);
                end else if (pick < 82) begin
                    send_record(1'b0, $urandom_range(1), 0);
                end else if (pick < 92) begin
                    send_record(1'b1, 1'b1, $urandom_range(1, 11 + 2 * int'(posts_now)));
                end else begin
                    // noise: random bytes with stray frame starts
                    repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(3) == 0);
                    need_start = 1'b1;
                end
                if ($urandom_range(99) == 0) begin
                    settle();
                end
            end
        end

        settle();
        $display("checked %0d posts and %0d record summaries from %0d bytes",
                 posts_checked, summaries_checked, bytes_sent);
        $display("%0d post-count settings from 0 to 4095, four idle/stall mixes",
                 settings_used);
        if (mismatch_count == 0 && awaited_count == 0) begin
            $display("PASS elevation_record_parser");
        end else begin
            $display("FAIL elevation_record_parser");
        end
        $finish;
    end

endmodule
